// ===== hdl/pwbe_pkg.sv =====
// ----------------------------------------------------------------------------
// pwbe_pkg: shared types and constants of the pulse-width byte encoder
// This package holds the byte descriptor, the segment width set, the register
// indexes and the slot numbering of the segment sequence.
// ----------------------------------------------------------------------------
package pwbe_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_LONG  = 2'd0;
    localparam logic [1:0] REG_SHORT = 2'd1;
    localparam logic [1:0] REG_TAIL  = 2'd2;

    // Reset values of the width registers
    localparam logic [15:0] LONG_RESET  = 16'd100;
    localparam logic [15:0] SHORT_RESET = 16'd40;
    localparam logic [15:0] TAIL_RESET  = 16'd800;

    // Slot numbering of one byte's segment sequence:
    // start, sixteen data segments, two parity segments, tail
    localparam logic [4:0] SLOT_START     = 5'd0;
    localparam logic [4:0] SLOT_FIRST_BIT = 5'd1;
    localparam logic [4:0] SLOT_LAST_SYM  = 5'd18;
    localparam logic [4:0] SLOT_TAIL      = 5'd19;

    // Symbol number of the parity symbol
    localparam logic [3:0] SYM_PARITY = 4'd8;

    // One classified byte, as passed from front to back
    typedef struct packed {
        logic [7:0] cmd_byte;
        logic       parity;
        logic       first_byte;
        logic       last_byte;
    } desc_t;

    // Current segment widths
    typedef struct packed {
        logic [15:0] long_width;
        logic [15:0] short_width;
        logic [15:0] tail_width;
    } widths_t;

endpackage

// ===== hdl/pwbe_front.sv =====
// ----------------------------------------------------------------------------
// pwbe_front: input stage of the encoder
// Accepts command bytes, works out their parity symbol and holds the
// resulting descriptor until the queue takes it.
// ----------------------------------------------------------------------------
module pwbe_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_first,
    input  logic          in_last,
    output logic          desc_valid,
    input  logic          desc_ready,
    output pwbe_pkg::desc_t desc
);
    import pwbe_pkg::*;

    logic  hold_valid_reg;
    desc_t desc_reg;
    desc_t desc_next;

    // Stage is free when empty or when its word leaves this cycle
    assign in_ready   = !hold_valid_reg || desc_ready;
    assign desc_valid = hold_valid_reg;
    assign desc       = desc_reg;

    // Classify: odd number of ones sends a one as parity symbol
    always_comb
    begin
        desc_next.cmd_byte   = in_byte;
        desc_next.parity     = ^in_byte;
        desc_next.first_byte = in_first;
        desc_next.last_byte  = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            desc_reg <= desc_next;
        end
    end

endmodule

// ===== hdl/pwbe_queue.sv =====
// ----------------------------------------------------------------------------
// pwbe_queue: two-entry descriptor queue
// Decouples the input stage from the segment sequencer so that either side
// can stall on its own.
// ----------------------------------------------------------------------------
module pwbe_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  pwbe_pkg::desc_t push_desc,
    output logic            pop_valid,
    input  logic            pop_ready,
    output pwbe_pkg::desc_t pop_desc
);
    import pwbe_pkg::*;

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== hdl/pwbe_back.sv =====
// ----------------------------------------------------------------------------
// pwbe_back: segment sequencer
// Steps through the segment slots of one descriptor, one per cycle while the
// output is not stalled, and drives each duration into an output register.
// ----------------------------------------------------------------------------
module pwbe_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  pwbe_pkg::widths_t widths,
    input  logic              desc_valid,
    output logic              desc_ready,
    input  pwbe_pkg::desc_t   desc,
    output logic              seg_valid,
    input  logic              seg_ready,
    output logic [15:0]       seg_duration,
    output logic              seg_run_end
);
    import pwbe_pkg::*;

    logic        busy_reg;
    desc_t       cur_reg;
    logic [4:0]  slot_reg;
    logic        out_valid_reg;
    logic [15:0] out_duration_reg;
    logic        out_run_end_reg;

    logic        advance;
    logic        is_end;
    logic [4:0]  bit_slot;
    logic [3:0]  sym;
    logic        sym_bit;
    logic [15:0] duration_next;

    assign seg_valid    = out_valid_reg;
    assign seg_duration = out_duration_reg;
    assign seg_run_end  = out_run_end_reg;

    // Emit a segment whenever the output register is free or draining
    assign advance    = busy_reg && (!out_valid_reg || seg_ready);
    assign is_end     = cur_reg.last_byte ? (slot_reg == SLOT_TAIL)
                                          : (slot_reg == SLOT_LAST_SYM);
    assign desc_ready = !busy_reg || (advance && is_end);

    // Duration of the current slot; within a symbol the first half is long
    // for a one and the second half is long for a zero
    always_comb
    begin
        bit_slot = slot_reg - SLOT_FIRST_BIT;
        sym      = bit_slot[4:1];
        sym_bit  = (sym == SYM_PARITY) ? cur_reg.parity : cur_reg.cmd_byte[sym[2:0]];
        if (slot_reg == SLOT_START)
        begin
            duration_next = widths.long_width;
        end
        else if (slot_reg == SLOT_TAIL)
        begin
            duration_next = widths.tail_width;
        end
        else if (sym_bit ^ bit_slot[0])
        begin
            duration_next = widths.long_width;
        end
        else
        begin
            duration_next = widths.short_width;
        end
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= SLOT_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (desc_valid && desc_ready)
            begin
                busy_reg <= 1'b1;
                slot_reg <= desc.first_byte ? SLOT_START : SLOT_FIRST_BIT;
            end
            else if (advance && is_end)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                slot_reg <= slot_reg + 5'd1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (seg_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (desc_valid && desc_ready)
        begin
            cur_reg <= desc;
        end
        if (advance)
        begin
            out_duration_reg <= duration_next;
            out_run_end_reg  <= is_end;
        end
    end

endmodule

// ===== hdl/pulse_width_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// pulse_width_byte_encoder: pulse-width line code with even parity
// Path: front register, queue, segment sequencer and its output register.
// Throughput: one segment word per cycle while the output is not stalled;
// 18 to 20 words per byte (18 plus one for a start and one for a tail
// segment). Bytes are accepted back to back into a two-entry queue meanwhile.
// Reset: asynchronous, active low; clears all control state and loads the
// widths long 100, short 40, tail 800.
// ----------------------------------------------------------------------------
module pulse_width_byte_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    // Input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic        s_axis_tuser,   // first_byte
    // Output segment stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] duration
    output logic        m_axis_tlast,   // run_end
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pwbe_pkg::*;

    widths_t widths_reg;
    logic    fq_valid;
    logic    fq_ready;
    desc_t   fq_desc;
    logic    qb_valid;
    logic    qb_ready;
    desc_t   qb_desc;

    assign cfg_ready = 1'b1;

    // Width registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widths_reg.long_width  <= LONG_RESET;
            widths_reg.short_width <= SHORT_RESET;
            widths_reg.tail_width  <= TAIL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LONG:  widths_reg.long_width  <= cfg_data;
                REG_SHORT: widths_reg.short_width <= cfg_data;
                REG_TAIL:  widths_reg.tail_width  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Front: accept and classify
    pwbe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_first   (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .desc_valid (fq_valid),
        .desc_ready (fq_ready),
        .desc       (fq_desc)
    );

    // Queue between front and back
    pwbe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_desc  (fq_desc),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_desc   (qb_desc)
    );

    // Back: segment sequencer
    pwbe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .widths       (widths_reg),
        .desc_valid   (qb_valid),
        .desc_ready   (qb_ready),
        .desc         (qb_desc),
        .seg_valid    (m_axis_tvalid),
        .seg_ready    (m_axis_tready),
        .seg_duration (m_axis_tdata),
        .seg_run_end  (m_axis_tlast)
    );

endmodule

// ===== dv/pwbe_checker.sv =====
// ----------------------------------------------------------------------------
// pwbe_checker: segment predictor and scoreboard for the pulse-width encoder
// Watches the configuration, byte and segment channels. Every accepted byte
// is expanded into its expected segment words. Every accepted segment word
// is compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module pwbe_checker
(
    input  logic        clk,
    input  logic        rst_n,
    // Byte stream
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic        s_axis_tuser,   // first_byte
    // Segment stream
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] duration
    input  logic        m_axis_tlast,   // run_end
    // Configuration channel
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Status to the test
    output int          errors,
    output int          pending
);
    import pwbe_pkg::*;

    typedef struct packed {
        logic [15:0] duration;
        logic        run_end;
    } seg_t;

    widths_t widths;
    seg_t    seg_q[$];

    initial errors = 0;

    function automatic void add_seg(input logic [15:0] dur, input logic run_end);
        seg_t s;
        s.duration = dur;
        s.run_end  = run_end;
        seg_q.push_back(s);
    endfunction

    // Optional start, eight bit symbols LSB first, parity symbol, optional tail
    function automatic void predict_segments(input logic [7:0] cmd, input logic first,
                                             input logic last);
        int   i;
        logic one;
        if (first)
            add_seg(widths.long_width, 1'b0);
        for (i = 0; i < 8; i++)
        begin
            one = cmd[i];
            add_seg(one ? widths.long_width : widths.short_width, 1'b0);
            add_seg(one ? widths.short_width : widths.long_width, 1'b0);
        end
        // odd count of ones codes the parity symbol as a one
        one = ^cmd;
        add_seg(one ? widths.long_width : widths.short_width, 1'b0);
        add_seg(one ? widths.short_width : widths.long_width, !last);
        if (last)
            add_seg(widths.tail_width, 1'b1);
    endfunction

    // Channel monitor: compare outgoing words, then take config and bytes
    always @(posedge clk or negedge rst_n)
    begin : monitor
        seg_t got;
        seg_t want;
        if (!rst_n)
        begin
            widths.long_width  = LONG_RESET;
            widths.short_width = SHORT_RESET;
            widths.tail_width  = TAIL_RESET;
            seg_q.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.duration = m_axis_tdata;
                got.run_end  = m_axis_tlast;
                if (seg_q.size() == 0)
                begin
                    $display("%0t: unexpected segment word, duration %0d run_end %0b",
                             $time, got.duration, got.run_end);
                    errors = errors + 1;
                end
                else
                begin
                    want = seg_q.pop_front();
                    if (got.duration !== want.duration)
                    begin
                        $display("%0t: duration expected %0d got %0d",
                                 $time, want.duration, got.duration);
                        errors = errors + 1;
                    end
                    if (got.run_end !== want.run_end)
                    begin
                        $display("%0t: run_end expected %0b got %0b",
                                 $time, want.run_end, got.run_end);
                        errors = errors + 1;
                    end
                end
            end

            // register writes; an unused index changes nothing
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LONG:  widths.long_width  = cfg_data;
                    REG_SHORT: widths.short_width = cfg_data;
                    REG_TAIL:  widths.tail_width  = cfg_data;
                    default:   ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_segments(s_axis_tdata, s_axis_tuser, s_axis_tlast);

            pending <= seg_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the pulse-width byte encoder
// Drives directed and random command bytes, mostly as well-formed frames,
// through several width settings including zero and both extremes, with
// random gaps and stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import pwbe_pkg::*;

    // Index outside the register map, writes there must be dropped
    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 800000;
    localparam int         HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    int   errors;
    int   pending;
    int   cycles = 0;
    int   tx_burst = 0;
    logic hold_req = 1'b0;

    pulse_width_byte_encoder u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pwbe_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Segment receiver: random stalls, bursts, and one long hold-off on request
    initial
    begin : receiver
        int   stall_left;
        int   free_left;
        int   hold_left;
        int   r;
        logic hold_ack;
        stall_left = 0;
        free_left  = 0;
        hold_left  = 0;
        hold_ack   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (free_left > 0)
            begin
                free_left = free_left - 1;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    m_axis_tready <= 1'b1;
                else if (r < 90)
                begin
                    stall_left = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end
                else if (r < 95)
                begin
                    stall_left = $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    free_left = $urandom_range(20, 80);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Gap before the next byte: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (tx_burst > 0)
        begin
            tx_burst = tx_burst - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 10)
            tx_burst = $urandom_range(10, 30);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte word and hold it until accepted
    task automatic send_word(input logic [7:0] cmd, input logic first, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tuser  <= 1'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Random traffic: mostly whole frames of random bytes, some stray bytes
    task automatic send_frames(input int count);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                    send_word(8'($urandom), k == 0, k == len - 1);
                sent = sent + len;
            end
            else
            begin
                send_word(8'($urandom), 1'($urandom), 1'($urandom));
                sent = sent + 1;
            end
        end
    endtask

    // Let all expected words drain, then give the pipeline time to settle;
    // the first edge lets the count take in the byte accepted just before
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Program all widths back to back, with a stray write to the unused index
    task automatic program_widths(input logic [15:0] lw, input logic [15:0] sw,
                                  input logic [15:0] tw);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        int          k;
        idx[0] = REG_UNUSED;
        val[0] = 16'($urandom);
        idx[1] = REG_LONG;
        val[1] = lw;
        idx[2] = REG_SHORT;
        val[2] = sw;
        idx[3] = REG_TAIL;
        val[3] = tw;
        for (k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed bytes at reset widths: extremes, parity both ways, all flag mixes
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'hAA, 1'b0, 1'b0);
        send_word(8'h55, 1'b0, 1'b1);
        send_word(8'hFE, 1'b1, 1'b0);
        send_word(8'h7F, 1'b0, 1'b1);
        send_word(8'h0F, 1'b0, 1'b0);
        send_word(8'hF0, 1'b1, 1'b1);
        send_word(8'h03, 1'b0, 1'b1);
        send_word(8'hC8, 1'b1, 1'b0);
        wait_drained();

        // Smallest nonzero widths
        program_widths(16'd1, 16'd1, 16'd1);
        send_word(8'h00, 1'b1, 1'b1);
        send_frames(18);
        wait_drained();

        // Largest widths
        program_widths(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(8'hFF, 1'b1, 1'b1);
        send_frames(18);
        wait_drained();

        // Zero widths come out as zero durations
        program_widths(16'd0, 16'd0, 16'd0);
        send_word(8'h5A, 1'b1, 1'b1);
        send_frames(14);
        wait_drained();

        // Random widths, with the output held off long enough to back up the input
        program_widths(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                       16'($urandom_range(1, 65535)));
        hold_req <= ~hold_req;
        send_frames(25);
        wait_drained();

        // Lopsided widths
        program_widths(16'd1, 16'hFFFF, 16'($urandom));
        send_frames(20);
        wait_drained();

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
